// ===== rtl/rdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the radix digit converter pipeline.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VAL_W      = 63;
    localparam int ACC_W      = 64;
    localparam int BASE_W     = 4;
    localparam int DIG_W      = 4;
    localparam int NUM_DEC    = 19;
    localparam int NUM_TDIG   = 19;
    localparam int MAX_DIGITS = 19;
    localparam int BCD_W      = NUM_DEC * DIG_W;
    localparam int TDIG_W     = NUM_TDIG * DIG_W;
    localparam int TDATA_IN_W  = 72;
    localparam int TDATA_OUT_W = 72;

    localparam logic [BASE_W-1:0] RADIX_MIN = 4'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX = 4'd10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_BASE  = 2'd1,
        ST_BAD_DIGIT = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0]  bin;
        logic [BCD_W-1:0]  bcd;
        logic [BASE_W-1:0] sbase;
        logic [BASE_W-1:0] tbase;
        status_t           status;
    } split_t;

    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [ACC_W-1:0]  acc;
        logic [BASE_W-1:0] sbase;
        logic [BASE_W-1:0] tbase;
        status_t           status;
    } eval_t;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [TDIG_W-1:0] digs;
        logic [BASE_W-1:0] tbase;
        logic              ovf;
        status_t           status;
    } conv_t;

    typedef struct packed {
        logic [TDIG_W-1:0] digs;
        logic [ACC_W-1:0]  packed_val;
        logic              ovf;
        status_t           status;
    } pack_t;

endpackage

// ===== rtl/rdc_bcd_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_bcd_split
// Binary to BCD split, one input bit per stage (shift and add-3).
// ----------------------------------------------------------------------------
module rdc_bcd_split
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  rdc_pkg::split_t in_item,
    output logic            out_vld,
    output rdc_pkg::split_t out_item
);

    localparam int N = rdc_pkg::VAL_W;

    logic [N-1:0]    vld_reg;
    rdc_pkg::split_t stg_reg [N];

    function automatic rdc_pkg::split_t step(rdc_pkg::split_t x);
        rdc_pkg::split_t           y;
        logic [rdc_pkg::BCD_W-1:0] adj;
        logic [rdc_pkg::DIG_W-1:0] d;
        y = x;
        for (int i = 0; i < rdc_pkg::NUM_DEC; i++)
        begin
            d = x.bcd[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W];
            adj[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        y.bcd = {adj[rdc_pkg::BCD_W-2:0], x.bin[rdc_pkg::VAL_W-1]};
        y.bin = {x.bin[rdc_pkg::VAL_W-2:0], 1'b0};
        return y;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= step(in_item);
            for (int i = 1; i < N; i++)
            begin
                stg_reg[i] <= step(stg_reg[i-1]);
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_item = stg_reg[N-1];

endmodule

// ===== rtl/rdc_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_eval
// Digit check, then source-radix evaluation, one digit per stage, MSD first.
// ----------------------------------------------------------------------------
module rdc_eval
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  rdc_pkg::split_t in_item,
    output logic            out_vld,
    output rdc_pkg::eval_t  out_item
);

    localparam int N = rdc_pkg::NUM_DEC;

    logic [N-1:0]   vld_reg;
    rdc_pkg::eval_t stg_reg [N];

    function automatic rdc_pkg::eval_t horner(rdc_pkg::eval_t x);
        rdc_pkg::eval_t            y;
        logic [rdc_pkg::DIG_W-1:0] d;
        y     = x;
        d     = x.bcd[rdc_pkg::BCD_W-1 -: rdc_pkg::DIG_W];
        y.acc = x.acc * rdc_pkg::ACC_W'(x.sbase) + rdc_pkg::ACC_W'(d);
        y.bcd = {x.bcd[rdc_pkg::BCD_W-rdc_pkg::DIG_W-1:0], {rdc_pkg::DIG_W{1'b0}}};
        return y;
    endfunction

    function automatic rdc_pkg::eval_t first(rdc_pkg::split_t x);
        rdc_pkg::eval_t            y;
        logic [rdc_pkg::DIG_W-1:0] d;
        logic                      bad;
        bad = 1'b0;
        for (int i = 0; i < rdc_pkg::NUM_DEC; i++)
        begin
            d = x.bcd[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W];
            if ({1'b0, d} >= {1'b0, x.sbase})
            begin
                bad = 1'b1;
            end
            if (i >= rdc_pkg::MAX_DIGITS && d != '0)
            begin
                bad = 1'b1;
            end
        end
        y.bcd    = x.bcd;
        y.acc    = '0;
        y.sbase  = x.sbase;
        y.tbase  = x.tbase;
        y.status = (x.status == rdc_pkg::ST_OK && bad) ? rdc_pkg::ST_BAD_DIGIT : x.status;
        return horner(y);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= first(in_item);
            for (int i = 1; i < N; i++)
            begin
                stg_reg[i] <= horner(stg_reg[i-1]);
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_item = stg_reg[N-1];

endmodule

// ===== rtl/rdc_radix_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_radix_conv
// Binary to target-radix digits, one bit per stage, MSB first: digits double
// plus the incoming bit, carries resolved by a lookahead add.
// ----------------------------------------------------------------------------
module rdc_radix_conv
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  rdc_pkg::eval_t in_item,
    output logic           out_vld,
    output rdc_pkg::conv_t out_item
);

    localparam int N  = rdc_pkg::VAL_W;
    localparam int ND = rdc_pkg::NUM_TDIG;

    logic [N-1:0]   vld_reg;
    rdc_pkg::conv_t stg_reg [N];

    function automatic rdc_pkg::conv_t step(rdc_pkg::conv_t x);
        rdc_pkg::conv_t            y;
        logic [ND-1:0]             g;
        logic [ND-1:0]             p;
        logic [ND:0]               a;
        logic [ND:0]               b;
        logic [ND:0]               s;
        logic [ND:0]               c;
        logic [rdc_pkg::DIG_W:0]   dd;
        logic [rdc_pkg::DIG_W:0]   t5;
        logic [rdc_pkg::DIG_W:0]   nd;
        y  = x;
        t5 = {1'b0, x.tbase};
        for (int i = 0; i < ND; i++)
        begin
            dd   = {x.digs[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W], 1'b0};
            g[i] = (dd >= t5);
            p[i] = ((dd + 5'd1) == t5);
        end
        a = {1'b0, g | p};
        b = {1'b0, g};
        s = a + b + (ND+1)'(x.acc[rdc_pkg::ACC_W-2]);
        c = s ^ a ^ b;
        for (int i = 0; i < ND; i++)
        begin
            dd = {x.digs[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W], 1'b0};
            nd = dd + (rdc_pkg::DIG_W+1)'(c[i]) - (c[i+1] ? t5 : '0);
            y.digs[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W] = nd[rdc_pkg::DIG_W-1:0];
        end
        y.ovf = x.ovf | c[ND];
        y.acc = {x.acc[rdc_pkg::ACC_W-2:0], 1'b0};
        return y;
    endfunction

    function automatic rdc_pkg::conv_t first(rdc_pkg::eval_t x);
        rdc_pkg::conv_t y;
        y.acc    = x.acc;
        y.digs   = '0;
        y.tbase  = x.tbase;
        y.ovf    = 1'b0;
        y.status = x.status;
        return step(y);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= first(in_item);
            for (int i = 1; i < N; i++)
            begin
                stg_reg[i] <= step(stg_reg[i-1]);
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_item = stg_reg[N-1];

endmodule

// ===== rtl/rdc_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pack
// Packs target-radix digits as a decimal number, one digit per stage, and
// resolves the final status.
// ----------------------------------------------------------------------------
module rdc_pack
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  rdc_pkg::conv_t              in_item,
    output logic                        out_vld,
    output logic [rdc_pkg::VAL_W-1:0]   converted_digits,
    output rdc_pkg::status_t            status
);

    localparam int N = rdc_pkg::NUM_TDIG;

    logic [N-1:0]   vld_reg;
    rdc_pkg::pack_t stg_reg [N];
    rdc_pkg::pack_t last;

    function automatic rdc_pkg::pack_t step(rdc_pkg::pack_t x);
        rdc_pkg::pack_t            y;
        logic [rdc_pkg::DIG_W-1:0] d;
        y = x;
        d = x.digs[rdc_pkg::TDIG_W-1 -: rdc_pkg::DIG_W];
        y.packed_val = {x.packed_val[rdc_pkg::ACC_W-4:0], 3'b000}
                     + {x.packed_val[rdc_pkg::ACC_W-2:0], 1'b0}
                     + rdc_pkg::ACC_W'(d);
        y.digs = {x.digs[rdc_pkg::TDIG_W-rdc_pkg::DIG_W-1:0], {rdc_pkg::DIG_W{1'b0}}};
        return y;
    endfunction

    function automatic rdc_pkg::pack_t first(rdc_pkg::conv_t x);
        rdc_pkg::pack_t y;
        y.digs       = x.digs;
        y.packed_val = '0;
        y.ovf        = x.ovf;
        y.status     = x.status;
        return step(y);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= first(in_item);
            for (int i = 1; i < N; i++)
            begin
                stg_reg[i] <= step(stg_reg[i-1]);
            end
        end
    end

    assign last    = stg_reg[N-1];
    assign out_vld = vld_reg[N-1];

    always_comb
    begin
        if (last.status != rdc_pkg::ST_OK)
        begin
            status = last.status;
        end
        else if (last.ovf || last.packed_val[rdc_pkg::ACC_W-1])
        begin
            status = rdc_pkg::ST_OVERFLOW;
        end
        else
        begin
            status = rdc_pkg::ST_OK;
        end
        converted_digits = (status == rdc_pkg::ST_OK) ?
                           last.packed_val[rdc_pkg::VAL_W-1:0] : '0;
    end

endmodule

// ===== rtl/radix_digit_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Radix conversion (bases 2 to 10) of a decimal-packed number, pipelined.
//
//   channel | dir | tdata fields (lsb up)
//   s_axis  | in  | value_digits[62:0], source_base[66:63], target_base[70:67]
//   m_axis  | out | converted_digits[62:0], status[64:63]
//
// One transfer in per cycle unless the output stalls. Stages: 63 BCD split,
// 19 evaluate, 63 radix conversion, 19 pack.
// Asynchronous reset clears all stage valid bits.
// A stalled output freezes the whole pipeline; s_tready follows it.
// ----------------------------------------------------------------------------
module radix_digit_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // value_digits, source_base, target_base, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata   // converted_digits, status, pad
);

    logic                              en;
    logic                              in_vld;
    rdc_pkg::split_t                   in_item;
    logic                              split_vld;
    rdc_pkg::split_t                   split_item;
    logic                              eval_vld;
    rdc_pkg::eval_t                    eval_item;
    logic                              conv_vld;
    rdc_pkg::conv_t                    conv_item;
    logic                              out_vld;
    logic [rdc_pkg::VAL_W-1:0]         converted_digits;
    rdc_pkg::status_t                  status;
    logic [rdc_pkg::BASE_W-1:0]        source_base;
    logic [rdc_pkg::BASE_W-1:0]        target_base;

    assign en       = !out_vld || m_tready;
    assign s_tready = en;
    assign in_vld   = s_tvalid;
    assign m_tvalid = out_vld;

    assign source_base = s_tdata[66:63];
    assign target_base = s_tdata[70:67];

    always_comb
    begin
        in_item.bin   = s_tdata[rdc_pkg::VAL_W-1:0];
        in_item.bcd   = '0;
        in_item.sbase = source_base;
        in_item.tbase = target_base;
        if (source_base < rdc_pkg::RADIX_MIN || source_base > rdc_pkg::RADIX_MAX ||
            target_base < rdc_pkg::RADIX_MIN || target_base > rdc_pkg::RADIX_MAX)
        begin
            in_item.status = rdc_pkg::ST_BAD_BASE;
        end
        else
        begin
            in_item.status = rdc_pkg::ST_OK;
        end
    end

    rdc_bcd_split u_split
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_vld),
        .in_item  (in_item),
        .out_vld  (split_vld),
        .out_item (split_item)
    );

    rdc_eval u_eval
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (split_vld),
        .in_item  (split_item),
        .out_vld  (eval_vld),
        .out_item (eval_item)
    );

    rdc_radix_conv u_conv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (eval_vld),
        .in_item  (eval_item),
        .out_vld  (conv_vld),
        .out_item (conv_item)
    );

    rdc_pack u_pack
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_vld           (conv_vld),
        .in_item          (conv_item),
        .out_vld          (out_vld),
        .converted_digits (converted_digits),
        .status           (status)
    );

    assign m_tdata = {7'b0, status, converted_digits};

endmodule
